// ===== rtl/core/rcc_pkg.sv =====
// Package for the RGB/clear ratio color classifier: payload structs, pipeline
// stage types, register indexes, reset values and the box test function.
// No dependencies.
package rcc_pkg;

  localparam int unsigned CountWidth = 16;
  localparam int unsigned LevelWidth = 8;
  localparam int unsigned BoxWidth   = 48;
  localparam int unsigned NumLanes   = 4;
  localparam int unsigned NumSteps   = 8;

  // Lane order inside a pipeline stage.
  localparam int unsigned LANE_RED   = 0;
  localparam int unsigned LANE_GREEN = 1;
  localparam int unsigned LANE_BLUE  = 2;
  localparam int unsigned LANE_LIGHT = 3;

  // Configuration register indexes.
  localparam logic [1:0] REG_FIRST_BOX  = 2'd0;
  localparam logic [1:0] REG_SECOND_BOX = 2'd1;
  localparam logic [1:0] REG_FULL_SCALE = 2'd2;

  localparam logic [BoxWidth-1:0]   FIRST_BOX_RESET  = 48'd55140624992100;
  localparam logic [BoxWidth-1:0]   SECOND_BOX_RESET = 48'd148886556725794;
  localparam logic [CountWidth-1:0] FULL_SCALE_RESET = 16'd45000;

  localparam logic [LevelWidth-1:0] LEVEL_MAX = 8'd255;

  localparam logic [1:0] CLASS_NONE   = 2'd0;
  localparam logic [1:0] CLASS_FIRST  = 2'd1;
  localparam logic [1:0] CLASS_SECOND = 2'd2;

  typedef struct packed {
    logic [CountWidth-1:0] red_count;
    logic [CountWidth-1:0] green_count;
    logic [CountWidth-1:0] blue_count;
    logic [CountWidth-1:0] clear_count;
  } sample_t;

  typedef struct packed {
    logic [LevelWidth-1:0] red_level;
    logic [LevelWidth-1:0] green_level;
    logic [LevelWidth-1:0] blue_level;
    logic [LevelWidth-1:0] light_level;
    logic [1:0]            color_class;
    logic                  zero_clear;
  } result_t;

  // One division lane: partial remainder, dividend bits still to be shifted in,
  // divisor, quotient bits so far and the saturation flag.
  typedef struct packed {
    logic [CountWidth-1:0] rem;
    logic [LevelWidth-1:0] low;
    logic [CountWidth-1:0] den;
    logic [LevelWidth-1:0] quo;
    logic                  sat;
  } lane_t;

  typedef struct packed {
    logic                      valid;
    logic                      zero_clear;
    lane_t [NumLanes-1:0]      lane;
  } stage_t;

  function automatic logic in_box(logic [BoxWidth-1:0]   box,
                                  logic [LevelWidth-1:0] r,
                                  logic [LevelWidth-1:0] g,
                                  logic [LevelWidth-1:0] b);
    return (box[7:0]   <= r) && (r <= box[15:8])
        && (box[23:16] <= g) && (g <= box[31:24])
        && (box[39:32] <= b) && (b <= box[47:40]);
  endfunction

endpackage

// ===== rtl/core/rcc_prep.sv =====
// Entry stage of the classifier pipeline: forms count*255 for each lane,
// loads the first partial remainder and flags saturation. Uses rcc_pkg.
module rcc_prep (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic                          valid,
  input  rcc_pkg::sample_t              sample,
  input  logic [rcc_pkg::CountWidth-1:0] full_scale,
  output rcc_pkg::stage_t               stage
);

  rcc_pkg::stage_t stage_next;

  always_comb begin
    logic [rcc_pkg::CountWidth-1:0] num [rcc_pkg::NumLanes];
    logic [rcc_pkg::CountWidth-1:0] den [rcc_pkg::NumLanes];
    logic [23:0]                    prod;
    num[rcc_pkg::LANE_RED]   = sample.red_count;
    num[rcc_pkg::LANE_GREEN] = sample.green_count;
    num[rcc_pkg::LANE_BLUE]  = sample.blue_count;
    num[rcc_pkg::LANE_LIGHT] = sample.clear_count;
    den[rcc_pkg::LANE_RED]   = sample.clear_count;
    den[rcc_pkg::LANE_GREEN] = sample.clear_count;
    den[rcc_pkg::LANE_BLUE]  = sample.clear_count;
    den[rcc_pkg::LANE_LIGHT] = full_scale;
    stage_next.valid      = valid;
    stage_next.zero_clear = (sample.clear_count == '0);
    for (int i = 0; i < rcc_pkg::NumLanes; i++) begin
      prod = {num[i], 8'd0} - {8'd0, num[i]};
      stage_next.lane[i].rem = prod[23:8];
      stage_next.lane[i].low = prod[7:0];
      stage_next.lane[i].den = den[i];
      stage_next.lane[i].quo = '0;
      // The quotient exceeds 255 exactly when the upper product bits reach the
      // divisor. A zero divisor saturates unless the dividend is zero too.
      stage_next.lane[i].sat = (prod >= {den[i], 8'd0}) && (num[i] != '0);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage.valid <= 1'b0;
    end else if (en) begin
      stage <= stage_next;
    end
  end

endmodule

// ===== rtl/core/rcc_div_cell.sv =====
// One restoring division step for all four lanes, registered. A row of eight
// of these cells produces the 8-bit quotients. Uses rcc_pkg.
module rcc_div_cell (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  rcc_pkg::stage_t prev,
  output rcc_pkg::stage_t stage
);

  rcc_pkg::stage_t stage_next;

  always_comb begin
    logic [rcc_pkg::CountWidth:0] trial;
    logic [rcc_pkg::CountWidth:0] diff;
    logic                         fits;
    stage_next = prev;
    for (int i = 0; i < rcc_pkg::NumLanes; i++) begin
      trial = {prev.lane[i].rem, prev.lane[i].low[7]};
      diff  = trial - {1'b0, prev.lane[i].den};
      // A zero divisor never fits, so zero over zero gives a zero quotient.
      fits  = (prev.lane[i].den != '0) && (trial >= {1'b0, prev.lane[i].den});
      stage_next.lane[i].rem = fits ? diff[rcc_pkg::CountWidth-1:0]
                                    : trial[rcc_pkg::CountWidth-1:0];
      stage_next.lane[i].low = {prev.lane[i].low[6:0], 1'b0};
      stage_next.lane[i].quo = {prev.lane[i].quo[6:0], fits};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage.valid <= 1'b0;
    end else if (en) begin
      stage <= stage_next;
    end
  end

endmodule

// ===== rtl/core/rcc_classify.sv =====
// Output stage: applies saturation and the zero-clear rule, tests the two
// boxes and holds the result register. Uses rcc_pkg.
module rcc_classify (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         en,
  input  rcc_pkg::stage_t              prev,
  input  logic [rcc_pkg::BoxWidth-1:0] first_box,
  input  logic [rcc_pkg::BoxWidth-1:0] second_box,
  output logic                         valid,
  output rcc_pkg::result_t             result
);

  rcc_pkg::result_t result_next;

  always_comb begin
    logic [rcc_pkg::LevelWidth-1:0] lvl [rcc_pkg::NumLanes];
    for (int i = 0; i < rcc_pkg::NumLanes; i++) begin
      lvl[i] = prev.lane[i].sat ? rcc_pkg::LEVEL_MAX : prev.lane[i].quo;
    end
    result_next.red_level   = prev.zero_clear ? '0 : lvl[rcc_pkg::LANE_RED];
    result_next.green_level = prev.zero_clear ? '0 : lvl[rcc_pkg::LANE_GREEN];
    result_next.blue_level  = prev.zero_clear ? '0 : lvl[rcc_pkg::LANE_BLUE];
    result_next.light_level = lvl[rcc_pkg::LANE_LIGHT];
    result_next.zero_clear  = prev.zero_clear;
    // The first box has priority when both match.
    priority if (rcc_pkg::in_box(first_box, result_next.red_level,
                                 result_next.green_level, result_next.blue_level)) begin
      result_next.color_class = rcc_pkg::CLASS_FIRST;
    end else if (rcc_pkg::in_box(second_box, result_next.red_level,
                                 result_next.green_level, result_next.blue_level)) begin
      result_next.color_class = rcc_pkg::CLASS_SECOND;
    end else begin
      result_next.color_class = rcc_pkg::CLASS_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (en) begin
      valid <= prev.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      result <= result_next;
    end
  end

endmodule

// ===== rtl/core/rgb_clear_ratio_color_classifier_core.sv =====
// RGB/clear ratio color classifier: four 8-step restoring dividers run as a
// row of division cells, followed by the box test and the output register.
// Throughput is one sample per cycle while the output is not stalled; each
// stage advances when it is empty or its successor advances, so bubbles
// close up under a stalled output. Synchronous reset empties the pipeline
// and loads the default box bounds and full scale.
module rgb_clear_ratio_color_classifier_core (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         sample_valid,
  output logic                         sample_ready,
  input  rcc_pkg::sample_t             sample,
  output logic                         result_valid,
  input  logic                         result_ready,
  output rcc_pkg::result_t             result,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [1:0]                   cfg_index,
  input  logic [rcc_pkg::BoxWidth-1:0] cfg_data
);

  localparam int unsigned Steps = rcc_pkg::NumSteps;

  logic [rcc_pkg::BoxWidth-1:0]   first_box;
  logic [rcc_pkg::BoxWidth-1:0]   second_box;
  logic [rcc_pkg::CountWidth-1:0] full_scale;

  rcc_pkg::stage_t stage [Steps+1];
  logic            en    [Steps+2];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      first_box  <= rcc_pkg::FIRST_BOX_RESET;
      second_box <= rcc_pkg::SECOND_BOX_RESET;
      full_scale <= rcc_pkg::FULL_SCALE_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        rcc_pkg::REG_FIRST_BOX:  first_box  <= cfg_data;
        rcc_pkg::REG_SECOND_BOX: second_box <= cfg_data;
        rcc_pkg::REG_FULL_SCALE: full_scale <= cfg_data[rcc_pkg::CountWidth-1:0];
        default: ;
      endcase
    end
  end

  // en[k] loads stage k; the output register is the last one.
  always_comb begin
    en[Steps+1] = !result_valid || result_ready;
    for (int k = Steps; k >= 0; k--) begin
      en[k] = !stage[k].valid || en[k+1];
    end
  end

  assign sample_ready = en[0];

  rcc_prep u_prep (
    .clk        (clk),
    .rst        (rst),
    .en         (en[0]),
    .valid      (sample_valid),
    .sample     (sample),
    .full_scale (full_scale),
    .stage      (stage[0])
  );

  for (genvar k = 1; k <= Steps; k++) begin : g_cell
    rcc_div_cell u_cell (
      .clk   (clk),
      .rst   (rst),
      .en    (en[k]),
      .prev  (stage[k-1]),
      .stage (stage[k])
    );
  end

  rcc_classify u_classify (
    .clk        (clk),
    .rst        (rst),
    .en         (en[Steps+1]),
    .prev       (stage[Steps]),
    .first_box  (first_box),
    .second_box (second_box),
    .valid      (result_valid),
    .result     (result)
  );

endmodule

// ===== rtl/core/rcc_checker.sv =====
// Port-level checks for the classifier core and the bind that attaches them.
// Uses rcc_pkg and rgb_clear_ratio_color_classifier_core.
module rcc_checker (
  input logic             clk,
  input logic             rst,
  input logic             result_valid,
  input logic             result_ready,
  input rcc_pkg::result_t result
);

  // A result that is not taken stays in place.
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result))
    else $error("result changed while stalled");

  a_zero_clear_levels: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.zero_clear |->
      result.red_level == '0 && result.green_level == '0 &&
      result.blue_level == '0 && result.light_level == '0)
    else $error("zero clear count with nonzero levels");

  a_class_code: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> result.color_class != 2'd3)
    else $error("unused class code");

  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !result_valid)
    else $error("result valid right after reset");

endmodule

bind rgb_clear_ratio_color_classifier_core rcc_checker u_rcc_checker (
  .clk          (clk),
  .rst          (rst),
  .result_valid (result_valid),
  .result_ready (result_ready),
  .result       (result)
);

// ===== bench/testbench.sv =====
// Self-checking bench for rgb_clear_ratio_color_classifier_core: directed table, then random
// sensor samples under several register settings, checked against an in-bench predictor.
// Depends on rcc_pkg and the core module only.
module testbench;

  localparam int unsigned PIPE_LATENCY     = 10;
  localparam int unsigned CYCLE_LIMIT      = 1000000;
  localparam int unsigned NUM_PHASES       = 8;
  localparam int unsigned ITEMS_PER_PHASE  = 190;
  localparam int unsigned NUM_DIRECTED     = 20;
  localparam int unsigned LONG_HOLD_AT     = 300;
  localparam int unsigned LONG_HOLD_CYCLES = 200;
  localparam int unsigned MAX_REPORTS      = 10;
  localparam logic [1:0]  REG_UNUSED       = 2'd3;

  typedef struct packed {
    rcc_pkg::sample_t counts;
    logic             typed;
    rcc_pkg::result_t want;
  } stim_row_t;

  logic                         clk;
  logic                         rst;
  logic                         sample_valid;
  logic                         sample_ready;
  rcc_pkg::sample_t             sample;
  logic                         result_valid;
  logic                         result_ready;
  rcc_pkg::result_t             result;
  logic                         cfg_valid;
  logic                         cfg_ready;
  logic [1:0]                   cfg_index;
  logic [rcc_pkg::BoxWidth-1:0] cfg_data;

  // Bench copy of the registers, updated when a write transfer completes.
  logic [rcc_pkg::BoxWidth-1:0]   yellow_box;
  logic [rcc_pkg::BoxWidth-1:0]   blue_box;
  logic [rcc_pkg::CountWidth-1:0] light_scale;

  rcc_pkg::result_t predicted_results[$];
  int unsigned      mismatches;
  int unsigned      results_seen;
  int unsigned      sent_count;
  bit               sender_steady;

  // Rows with want filled in were worked out by hand for the reset register values.
  stim_row_t directed_rows [NUM_DIRECTED] = '{
    '{'{16'd0, 16'd0, 16'd0, 16'd0}, 1'b1,
      '{8'd0, 8'd0, 8'd0, 8'd0, rcc_pkg::CLASS_NONE, 1'b1}},
    '{'{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd0}, 1'b1,
      '{8'd0, 8'd0, 8'd0, 8'd0, rcc_pkg::CLASS_NONE, 1'b1}},
    '{'{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF}, 1'b1,
      '{8'd255, 8'd255, 8'd255, 8'd255, rcc_pkg::CLASS_NONE, 1'b0}},
    '{'{16'd0, 16'd0, 16'd0, 16'd1}, 1'b1,
      '{8'd0, 8'd0, 8'd0, 8'd0, rcc_pkg::CLASS_NONE, 1'b0}},
    '{'{16'hFFFF, 16'd0, 16'd0, 16'd1}, 1'b1,
      '{8'd255, 8'd0, 8'd0, 8'd0, rcc_pkg::CLASS_NONE, 1'b0}},
    '{'{16'd45000, 16'd45000, 16'd45000, 16'd45000}, 1'b1,
      '{8'd255, 8'd255, 8'd255, 8'd255, rcc_pkg::CLASS_NONE, 1'b0}},
    '{'{16'd120, 16'd100, 16'd45, 16'd255}, 1'b1,
      '{8'd120, 8'd100, 8'd45, 8'd1, rcc_pkg::CLASS_FIRST, 1'b0}},
    '{'{16'd50, 16'd85, 16'd120, 16'd255}, 1'b1,
      '{8'd50, 8'd85, 8'd120, 8'd1, rcc_pkg::CLASS_SECOND, 1'b0}},
    '{'{16'd100, 16'd93, 16'd38, 16'd255}, 1'b0, '0},
    '{'{16'd135, 16'd109, 16'd50, 16'd255}, 1'b0, '0},
    '{'{16'd136, 16'd109, 16'd50, 16'd255}, 1'b0, '0},
    '{'{16'd99, 16'd93, 16'd38, 16'd255}, 1'b0, '0},
    '{'{16'd34, 16'd83, 16'd105, 16'd255}, 1'b0, '0},
    '{'{16'd82, 16'd90, 16'd135, 16'd255}, 1'b0, '0},
    '{'{16'd82, 16'd90, 16'd136, 16'd255}, 1'b0, '0},
    '{'{16'hAAAA, 16'h5555, 16'hFFFF, 16'h8000}, 1'b0, '0},
    '{'{16'h5555, 16'hAAAA, 16'h0001, 16'h7FFF}, 1'b0, '0},
    '{'{16'd100, 16'd100, 16'd100, 16'd44999}, 1'b0, '0},
    '{'{16'd100, 16'd100, 16'd100, 16'd45001}, 1'b0, '0},
    '{'{16'd65534, 16'd1, 16'd32768, 16'hFFFF}, 1'b0, '0}
  };

  rgb_clear_ratio_color_classifier_core i_dut (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_ready (sample_ready),
    .sample       (sample),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic logic [rcc_pkg::LevelWidth-1:0] scaled_level(
      logic [rcc_pkg::CountWidth-1:0] num,
      logic [rcc_pkg::CountWidth-1:0] den);
    int unsigned q;
    if (den == '0) return (num == '0) ? 8'd0 : rcc_pkg::LEVEL_MAX;
    q = (32'(num) * 32'd255) / 32'(den);
    return (q > 32'd255) ? rcc_pkg::LEVEL_MAX : q[7:0];
  endfunction

  // Each color owns 16 bits of the box: minimum in the low byte, maximum above it.
  function automatic bit box_hit(logic [rcc_pkg::BoxWidth-1:0] box, rcc_pkg::result_t lv);
    logic [rcc_pkg::LevelWidth-1:0] ch_level [3];
    ch_level[0] = lv.red_level;
    ch_level[1] = lv.green_level;
    ch_level[2] = lv.blue_level;
    for (int ch = 0; ch < 3; ch++) begin
      if (ch_level[ch] < box[16*ch +: 8] || ch_level[ch] > box[16*ch+8 +: 8]) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic rcc_pkg::result_t classify_sample(rcc_pkg::sample_t s);
    rcc_pkg::result_t r;
    r.zero_clear = (s.clear_count == '0);
    if (r.zero_clear) begin
      r.red_level   = '0;
      r.green_level = '0;
      r.blue_level  = '0;
    end else begin
      r.red_level   = scaled_level(s.red_count, s.clear_count);
      r.green_level = scaled_level(s.green_count, s.clear_count);
      r.blue_level  = scaled_level(s.blue_count, s.clear_count);
    end
    r.light_level = scaled_level(s.clear_count, light_scale);
    if (box_hit(yellow_box, r)) r.color_class = rcc_pkg::CLASS_FIRST;
    else if (box_hit(blue_box, r)) r.color_class = rcc_pkg::CLASS_SECOND;
    else r.color_class = rcc_pkg::CLASS_NONE;
    return r;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 50) return 0;
    else if (roll < 85) return $urandom_range(3, 1);
    else if (roll < 97) return $urandom_range(10, 4);
    else return $urandom_range(60, 20);
  endfunction

  // Picks levels inside the box (or just past one of its edges) and turns them back
  // into raw counts for a random clear count.
  function automatic rcc_pkg::sample_t aimed_sample(logic [rcc_pkg::BoxWidth-1:0] box);
    logic [rcc_pkg::CountWidth-1:0] clr;
    logic [rcc_pkg::CountWidth-1:0] cnt [3];
    int unsigned lo, hi, lvl;
    clr = ($urandom_range(3) == 0) ? 16'($urandom_range(2000, 1))
                                   : 16'($urandom_range(65535, 1));
    for (int ch = 0; ch < 3; ch++) begin
      lo = box[16*ch +: 8];
      hi = box[16*ch+8 +: 8];
      if (lo > hi) begin
        lo = 0;
        hi = 255;
      end
      lvl = $urandom_range(hi, lo);
      if ($urandom_range(9) == 0) lvl = ($urandom_range(1) == 1) ? hi + 1 : ((lo == 0) ? 0 : lo - 1);
      if (lvl > 255) lvl = 255;
      cnt[ch] = 16'((lvl * 32'(clr) + 254) / 255);
    end
    return '{cnt[0], cnt[1], cnt[2], clr};
  endfunction

  function automatic rcc_pkg::sample_t pick_random_sample();
    rcc_pkg::sample_t s;
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 35) begin
      s = aimed_sample(yellow_box);
    end else if (roll < 60) begin
      s = aimed_sample(blue_box);
    end else begin
      s = {$urandom, $urandom};
      if (roll < 70) s.clear_count = '0;
      else if (roll < 80) s.clear_count = 16'($urandom_range(300, 1));
    end
    return s;
  endfunction

  function automatic logic [rcc_pkg::BoxWidth-1:0] random_box();
    logic [rcc_pkg::BoxWidth-1:0] box;
    int unsigned lo, hi;
    if ($urandom_range(4) == 0) return {16'($urandom), $urandom};
    for (int ch = 0; ch < 3; ch++) begin
      lo = $urandom_range(255);
      hi = $urandom_range(255, lo);
      // Now and then swap the bounds so that the box cannot match unless the two bounds are equal.
      if ($urandom_range(6) == 0) box[16*ch +: 16] = {8'(lo), 8'(hi)};
      else box[16*ch +: 16] = {8'(hi), 8'(lo)};
    end
    return box;
  endfunction

  task automatic send_sample(rcc_pkg::sample_t s, logic typed, rcc_pkg::result_t typed_want);
    @(negedge clk);
    sample_valid <= 1'b1;
    sample       <= s;
    do @(posedge clk); while (!sample_ready);
    predicted_results.push_back(typed ? typed_want : classify_sample(s));
    sent_count++;
  endtask

  task automatic sender_gap();
    int unsigned n;
    n = sender_steady ? 0 : pick_gap();
    repeat (n) begin
      @(negedge clk);
      sample_valid <= 1'b0;
    end
  endtask

  task automatic wait_idle();
    @(negedge clk);
    sample_valid <= 1'b0;
    while (predicted_results.size() != 0) @(posedge clk);
    repeat (PIPE_LATENCY + 2) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [rcc_pkg::BoxWidth-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      rcc_pkg::REG_FIRST_BOX:  yellow_box = data;
      rcc_pkg::REG_SECOND_BOX: blue_box = data;
      rcc_pkg::REG_FULL_SCALE: light_scale = data[rcc_pkg::CountWidth-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic report_mismatch(string what, rcc_pkg::result_t want, rcc_pkg::result_t got);
    mismatches++;
    if (mismatches <= MAX_REPORTS) begin
      $display("result %0d %s: want r=%0d g=%0d b=%0d l=%0d cls=%0d zc=%0d",
               results_seen, what, want.red_level, want.green_level, want.blue_level,
               want.light_level, want.color_class, want.zero_clear);
      $display("    got r=%0d g=%0d b=%0d l=%0d cls=%0d zc=%0d",
               got.red_level, got.green_level, got.blue_level, got.light_level,
               got.color_class, got.zero_clear);
    end
  endtask

  always @(posedge clk) begin : result_check
    rcc_pkg::result_t want;
    if (!rst && result_valid && result_ready) begin
      results_seen++;
      if (predicted_results.size() == 0) begin
        report_mismatch("unexpected", '0, result);
      end else begin
        want = predicted_results.pop_front();
        if (result.red_level !== want.red_level || result.green_level !== want.green_level
            || result.blue_level !== want.blue_level
            || result.light_level !== want.light_level
            || result.color_class !== want.color_class
            || result.zero_clear !== want.zero_clear) begin
          report_mismatch("mismatch", want, result);
        end
      end
    end
  end

  initial begin : result_side
    int unsigned hold, stretch;
    bit steady, long_done;
    result_ready = 1'b0;
    hold = 0;
    stretch = 0;
    steady = 1'b0;
    long_done = 1'b0;
    forever begin
      @(negedge clk);
      // One long hold-off while the sender keeps offering, so the pipeline backs up.
      if (!long_done && sent_count >= LONG_HOLD_AT) begin
        long_done = 1'b1;
        hold = LONG_HOLD_CYCLES;
      end
      if (stretch == 0) begin
        steady = ($urandom_range(2) == 0);
        stretch = $urandom_range(200, 20);
      end else begin
        stretch--;
      end
      if (hold != 0) begin
        result_ready <= 1'b0;
        hold--;
      end else begin
        result_ready <= 1'b1;
        if (!steady) hold = pick_gap();
      end
    end
  end

  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin : stimulus
    logic [rcc_pkg::CountWidth-1:0] scale;
    rst           = 1'b1;
    sample_valid  = 1'b0;
    sample        = '0;
    cfg_valid     = 1'b0;
    cfg_index     = rcc_pkg::REG_FIRST_BOX;
    cfg_data      = '0;
    mismatches    = 0;
    results_seen  = 0;
    sent_count    = 0;
    sender_steady = 1'b0;
    yellow_box    = rcc_pkg::FIRST_BOX_RESET;
    blue_box      = rcc_pkg::SECOND_BOX_RESET;
    light_scale   = rcc_pkg::FULL_SCALE_RESET;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (int i = 0; i < NUM_DIRECTED; i++) begin
      send_sample(directed_rows[i].counts, directed_rows[i].typed, directed_rows[i].want);
      sender_gap();
    end
    wait_idle();

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        0: ;
        1: begin
          write_reg(rcc_pkg::REG_FIRST_BOX, 48'hFF00_FF00_FF00);
          write_reg(rcc_pkg::REG_SECOND_BOX, rcc_pkg::SECOND_BOX_RESET);
          write_reg(rcc_pkg::REG_FULL_SCALE, 48'hFFFF);
        end
        2: begin
          write_reg(rcc_pkg::REG_FIRST_BOX, '0);
          write_reg(rcc_pkg::REG_SECOND_BOX, 48'hFFFF_FFFF_FFFF);
          write_reg(rcc_pkg::REG_FULL_SCALE, 48'd1);
        end
        3: begin
          // Inverted first box never matches; zero full scale pins the light level.
          write_reg(rcc_pkg::REG_FIRST_BOX, 48'h3264_3264_3264);
          write_reg(rcc_pkg::REG_SECOND_BOX, 48'hFF00_FF00_FF00);
          write_reg(rcc_pkg::REG_FULL_SCALE, {16'hA5A5, 16'h5A5A, 16'd0});
        end
        4: begin
          // Identical boxes: whenever both match the first one has to win.
          write_reg(REG_UNUSED, {16'($urandom), $urandom});
          write_reg(rcc_pkg::REG_FIRST_BOX, rcc_pkg::FIRST_BOX_RESET);
          write_reg(rcc_pkg::REG_SECOND_BOX, rcc_pkg::FIRST_BOX_RESET);
          write_reg(rcc_pkg::REG_FULL_SCALE, 48'(rcc_pkg::FULL_SCALE_RESET));
        end
        default: begin
          if ($urandom_range(1) == 1) write_reg(REG_UNUSED, {16'($urandom), $urandom});
          write_reg(rcc_pkg::REG_FIRST_BOX, random_box());
          write_reg(rcc_pkg::REG_SECOND_BOX, random_box());
          if ($urandom_range(4) == 0) scale = 16'($urandom_range(50, 1));
          else scale = 16'($urandom_range(65535, 1));
          write_reg(rcc_pkg::REG_FULL_SCALE, {16'($urandom), 16'($urandom), scale});
        end
      endcase
      sender_steady = (ph % 3 == 1);
      if (ph > 0) begin
        send_sample({16'($urandom), 16'($urandom), 16'($urandom), 16'd0}, 1'b0, '0);
        send_sample({16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF}, 1'b0, '0);
        send_sample({16'd0, 16'd0, 16'd0, 16'hFFFF}, 1'b0, '0);
      end
      for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
        send_sample(pick_random_sample(), 1'b0, '0);
        sender_gap();
        // Let the pipeline run dry once in the middle of the first phase.
        if (ph == 0 && k == 100) wait_idle();
      end
      wait_idle();
    end

    repeat (PIPE_LATENCY * 3) @(posedge clk);
    if (mismatches == 0 && predicted_results.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
